FILE: rtl/ipc_pkg.sv
// Shared types, constants and window helpers for the isolated pixel counter.
// Used by ipc_front, ipc_back and isolated_pixel_counter; no dependencies.
package ipc_pkg;

   // default frame bounds
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 8;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 8'd10;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 8'd10;

   // register indexes (paddr bit 2)
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // result and window widths
   localparam int COUNT_W = 13;
   localparam int WIN_W   = 9;
   // 3x3 window with only the centre set
   localparam logic [WIN_W-1:0] ISOLATED_WIN = 9'b000_010_000;

   // per-pixel control word produced by the front
   typedef struct packed {
      logic px;
      logic up_en;
      logic mid_en;
      logic first_col;
      logic judge;
      logic row_end;
      logic last_frame;
   } ipc_flags_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_DRAIN,
      ST_EMIT
   } back_state_type;

   // shift a new 3-bit column (top, middle, bottom) into the low end
   function automatic logic [WIN_W-1:0] shift_in(input logic [WIN_W-1:0] win,
                                                 input logic [2:0] column);
      shift_in = {win[WIN_W-4:0], column};
   endfunction

   function automatic logic is_isolated(input logic [WIN_W-1:0] win);
      is_isolated = (win == ISOLATED_WIN);
   endfunction

endpackage

FILE: rtl/isolated_pixel_counter.sv
// Top level of the isolated pixel counter: register port, front, queue and back.
// Depends on ipc_pkg, ipc_front, ipc_queue and ipc_back.
//
//   channel   ports                        direction  moves
//   req       req_valid/ready, req_pixel   in         one pixel per transfer, raster order
//   rsp       rsp_valid/ready, rsp_*       out        one count per finished frame
//   csr       csr_psel ... csr_pready      in/out     frame_width at 0x0, frame_height at 0x4
//
// One pixel is taken per cycle while the queue has room; the back works each pixel
// through a line store read and a window update, pipelined.
// At the last pixel of a frame the back sweeps the last row through the line store
// read port, one column a cycle.
// Reset is synchronous, active high; the line store is not cleared.
// The result sits in an output register, so a stalled rsp side holds only the next
// frame's end, not the pixels before it.
module isolated_pixel_counter #(
   parameter int MAX_WIDTH  = ipc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ipc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_pixel,
   // count output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ipc_pkg::COUNT_W-1:0]      rsp_isolated_count,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
   localparam int FLAG_W = $bits(ipc_pkg::ipc_flags_type);
   localparam int Q_W    = FLAG_W + COL_W;
   localparam int CFG_W  = ipc_pkg::CFG_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write, restart;
   logic [WSZ_W-1:0] frame_w;
   logic [HSZ_W-1:0] frame_h;

   logic                   f_push, q_ready, q_valid, q_pop;
   ipc_pkg::ipc_flags_type f_flags, b_flags;
   logic [COL_W-1:0]       f_col, b_col;
   logic [Q_W-1:0]         q_out;

   // register port: write on the access cycle, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // any write restarts the frame
   assign restart    = csr_write;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            ipc_pkg::REG_FRAME_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            ipc_pkg::REG_FRAME_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ipc_pkg::FRAME_WIDTH_RESET;
         height_ff <= ipc_pkg::FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ipc_pkg::REG_FRAME_WIDTH:  csr_prdata = ipc_pkg::CSR_DATA_W'(width_ff);
         ipc_pkg::REG_FRAME_HEIGHT: csr_prdata = ipc_pkg::CSR_DATA_W'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // hold sizes within 1 .. maximum
   always_comb begin
      if (width_ff == '0) begin
         frame_w = WSZ_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         frame_w = WSZ_W'(MAX_WIDTH);
      end else begin
         frame_w = WSZ_W'(width_ff);
      end
      if (height_ff == '0) begin
         frame_h = HSZ_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         frame_h = HSZ_W'(MAX_HEIGHT);
      end else begin
         frame_h = HSZ_W'(height_ff);
      end
   end

   // classify pixels and advance position
   ipc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .frame_w   (frame_w),
      .frame_h   (frame_h),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .q_ready   (q_ready),
      .q_push    (f_push),
      .q_flags   (f_flags),
      .q_col     (f_col)
   );

   // decouple classification from the store and sweep
   ipc_queue #(
      .DATA_W (Q_W),
      .DEPTH  (ipc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_data  ({f_flags, f_col}),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out)
   );

   assign b_flags = ipc_pkg::ipc_flags_type'(q_out[Q_W-1:COL_W]);
   assign b_col   = q_out[COL_W-1:0];

   // line store, window, count and result register
   ipc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .restart            (restart),
      .frame_w            (frame_w),
      .h_ge2              (frame_h != HSZ_W'(1)),
      .q_valid            (q_valid),
      .q_flags            (b_flags),
      .q_col              (b_col),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_isolated_count (rsp_isolated_count)
   );

endmodule

FILE: rtl/ipc_queue.sv
// Small register queue that parts the front from the back.
// Generic data width; uses no package items.
module ipc_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ipc_front.sv
// Front end: accepts pixels, tracks raster position and classifies each pixel.
// Depends on ipc_pkg for the control word type.
module ipc_front #(
   parameter int MAX_WIDTH  = ipc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ipc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   frame_h,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_pixel,
   input  logic                              q_ready,
   output logic                              q_push,
   output ipc_pkg::ipc_flags_type            q_flags,
   output logic [$clog2(MAX_WIDTH)-1:0]      q_col
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WSZ_W-1:0] w_m1;
   logic [HSZ_W-1:0] h_m1;
   logic [COL_W-1:0] col_eff;
   logic [ROW_W-1:0] row_eff;
   logic             col_last, row_last;

   assign w_m1 = frame_w - WSZ_W'(1);
   assign h_m1 = frame_h - HSZ_W'(1);

   // hold positions inside the frame
   assign col_eff = (WSZ_W'(col_ff) >= frame_w) ? w_m1[COL_W-1:0] : col_ff;
   assign row_eff = (HSZ_W'(row_ff) >= frame_h) ? h_m1[ROW_W-1:0] : row_ff;

   assign col_last = (WSZ_W'(col_eff) == w_m1);
   assign row_last = (HSZ_W'(row_eff) == h_m1);

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;
   assign q_col     = col_eff;

   always_comb begin
      q_flags.px         = req_pixel;
      q_flags.up_en      = (row_eff >= ROW_W'(2));
      q_flags.mid_en     = (row_eff != '0);
      q_flags.first_col  = (col_eff == '0);
      q_flags.judge      = (row_eff != '0) && (col_eff != '0);
      q_flags.row_end    = (row_eff != '0) && col_last;
      q_flags.last_frame = col_last && row_last;
   end

   // advance raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_eff + ROW_W'(1);
         end else begin
            col_in = col_eff + COL_W'(1);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: rtl/ipc_back.sv
// Back end: line store, 3x3 window, isolation count, last-row sweep and result register.
// Depends on ipc_pkg for the control word, state type and window helpers.
module ipc_back #(
   parameter int MAX_WIDTH = ipc_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    frame_w,
   input  logic                              h_ge2,
   input  logic                              q_valid,
   input  ipc_pkg::ipc_flags_type            q_flags,
   input  logic [$clog2(MAX_WIDTH)-1:0]      q_col,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ipc_pkg::COUNT_W-1:0]       rsp_isolated_count
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
   localparam int WIN_W = ipc_pkg::WIN_W;
   localparam int CNT_W = ipc_pkg::COUNT_W;

   // line store: bit 1 = upper row, bit 0 = middle row
   logic [1:0] line_mem [MAX_WIDTH];

   ipc_pkg::back_state_type state_ff, state_in;

   logic                   s2_valid_ff;
   ipc_pkg::ipc_flags_type s2_flags_ff;
   logic [COL_W-1:0]       s2_col_ff;
   logic [1:0]             rd_ff;
   logic                   byp_ff, byp_in;
   logic [1:0]             byp_data_ff, wr_data;
   logic [COL_W-1:0]       fl_cnt_ff, fl_cnt_in;
   logic                   fl_v_ff, fl_first_ff, fl_last_ff;
   logic [WIN_W-1:0]       window_ff, window_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic                   pop, flush_issue, issue_last, rd_en, emit_load;
   logic [COL_W-1:0]       rd_addr;
   logic [WSZ_W-1:0]       w_m1;
   logic [1:0]             store_q;
   logic [2:0]             column;
   logic [WIN_W-1:0]       win0, win1;
   logic                   inc_a, inc_b;

   assign w_m1       = frame_w - WSZ_W'(1);
   assign issue_last = (WSZ_W'(fl_cnt_ff) == w_m1);

   // control outputs of the sequencer
   always_comb begin
      pop         = (state_ff == ipc_pkg::ST_RUN) && q_valid
                    && !(s2_valid_ff && s2_flags_ff.last_frame);
      flush_issue = (state_ff == ipc_pkg::ST_FLUSH);
      emit_load   = (state_ff == ipc_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
      rd_en       = pop || flush_issue;
      rd_addr     = flush_issue ? fl_cnt_ff : q_col;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipc_pkg::ST_RUN: begin
            if (s2_valid_ff && s2_flags_ff.last_frame) begin
               state_in = ipc_pkg::ST_FLUSH;
            end
         end
         ipc_pkg::ST_FLUSH: begin
            if (issue_last) begin
               state_in = ipc_pkg::ST_DRAIN;
            end
         end
         ipc_pkg::ST_DRAIN: begin
            state_in = ipc_pkg::ST_EMIT;
         end
         ipc_pkg::ST_EMIT: begin
            if (emit_load) begin
               state_in = ipc_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = ipc_pkg::ST_RUN;
         end
      endcase
   end

   assign q_pop = pop;

   // store data, with the word just written forwarded when addresses meet
   assign store_q = byp_ff ? byp_data_ff : rd_ff;
   assign wr_data = {store_q[0] & s2_flags_ff.mid_en, s2_flags_ff.px};
   assign byp_in  = pop && s2_valid_ff && (s2_col_ff == q_col);

   always_comb begin
      fl_cnt_in = fl_cnt_ff;
      if (flush_issue) begin
         fl_cnt_in = issue_last ? '0 : fl_cnt_ff + COL_W'(1);
      end
   end

   // window update and count
   always_comb begin
      column    = '0;
      win0      = window_ff;
      inc_a     = 1'b0;
      inc_b     = 1'b0;
      window_in = window_ff;
      if (fl_v_ff) begin
         column    = {store_q[1] & h_ge2, store_q[0], 1'b0};
         win0      = window_ff;
      end else begin
         column    = {store_q[1] & s2_flags_ff.up_en, store_q[0] & s2_flags_ff.mid_en,
                      s2_flags_ff.px};
         win0      = s2_flags_ff.first_col ? '0 : window_ff;
      end
      win1 = ipc_pkg::shift_in(win0, column);
      if (fl_v_ff) begin
         inc_a     = !fl_first_ff && ipc_pkg::is_isolated(win1);
         inc_b     = fl_last_ff && ipc_pkg::is_isolated(ipc_pkg::shift_in(win1, 3'b000));
         window_in = win1;
      end else if (s2_valid_ff) begin
         inc_a     = s2_flags_ff.judge && ipc_pkg::is_isolated(win1);
         inc_b     = s2_flags_ff.row_end
                     && ipc_pkg::is_isolated(ipc_pkg::shift_in(win1, 3'b000));
         // clear the window ahead of the last-row sweep
         window_in = s2_flags_ff.last_frame ? '0 : win1;
      end
      count_in = count_ff + CNT_W'(inc_a) + CNT_W'(inc_b);
      if (emit_load) begin
         count_in  = '0;
         window_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= ipc_pkg::ST_RUN;
         s2_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         fl_cnt_ff    <= '0;
         fl_v_ff      <= 1'b0;
         fl_first_ff  <= 1'b0;
         fl_last_ff   <= 1'b0;
         window_ff    <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         s2_valid_ff  <= pop;
         byp_ff       <= byp_in;
         fl_cnt_ff    <= fl_cnt_in;
         fl_v_ff      <= flush_issue;
         fl_first_ff  <= flush_issue && (fl_cnt_ff == '0);
         fl_last_ff   <= flush_issue && issue_last;
         window_ff    <= window_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_count_ff <= count_ff;
      end
      if (pop) begin
         s2_flags_ff <= q_flags;
         s2_col_ff   <= q_col;
      end
      byp_data_ff <= wr_data;
   end

   // line store ports
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         line_mem[s2_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= line_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_isolated_count = rsp_count_ff;

endmodule

FILE: dv/isolated_count_checker.sv
// Checker for the isolated pixel counter: follows the register port and both channels,
// predicts each frame's isolated pixel count and compares it with the rsp transfers.
// Depends on ipc_pkg for widths, bounds and register indexes.
module isolated_count_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_pixel,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [ipc_pkg::COUNT_W-1:0]    rsp_isolated_count,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ipc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ipc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             counts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ipc_pkg::*;

   localparam int LINE_LEN = DEF_MAX_WIDTH;

   logic [CFG_W-1:0]   width_cfg;
   logic [CFG_W-1:0]   height_cfg;
   bit                 upper_line [LINE_LEN];
   bit                 middle_line [LINE_LEN];
   logic [WIN_W-1:0]   window;
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [COUNT_W-1:0] tally;
   logic [COUNT_W-1:0] counts_due [$];
   logic [COUNT_W-1:0] finished;
   logic [COUNT_W-1:0] due;

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                              input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // newest column in the low bits: top, middle, bottom
   function automatic logic [WIN_W-1:0] push_column(input logic [WIN_W-1:0] win,
                                                    input logic [2:0] column);
      return {win[WIN_W-4:0], column};
   endfunction

   function automatic bit lone_pixel(input logic [WIN_W-1:0] win);
      return win[4] && ($countones(win) == 1);
   endfunction

   function automatic void restart_frame();
      window  = '0;
      col_pos = 0;
      row_pos = 0;
      tally   = '0;
   endfunction

   // advance the frame by one pixel; returns 1 with the frame's count on its last pixel
   function automatic bit take_pixel(input logic px, output logic [COUNT_W-1:0] frame_count);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      logic             up;
      logic             mid;
      logic [2:0]       column;
      logic [WIN_W-1:0] sweep;
      w = clamp_size(width_cfg, DEF_MAX_WIDTH);
      h = clamp_size(height_cfg, DEF_MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      frame_count = '0;
      up  = (r >= 2) ? upper_line[c] : 1'b0;
      mid = (r >= 1) ? middle_line[c] : 1'b0;
      if (c == 0) window = '0;
      window = push_column(window, {up, mid, px});
      upper_line[c]  = mid;
      middle_line[c] = px;
      // judge the pixel one row up and one column back
      if (r >= 1 && c >= 1) tally += COUNT_W'(lone_pixel(window));
      if (r >= 1 && c == w - 1) tally += COUNT_W'(lone_pixel(push_column(window, 3'b000)));
      if (c + 1 < w) begin
         col_pos = c + 1;
         return 1'b0;
      end
      if (r + 1 < h) begin
         col_pos = 0;
         row_pos = r + 1;
         return 1'b0;
      end
      // last row: nothing below it
      sweep = '0;
      for (int unsigned j = 0; j <= w; j++) begin
         column = 3'b000;
         if (j < w) column = {(h >= 2) ? upper_line[j] : 1'b0, middle_line[j], 1'b0};
         sweep = push_column(sweep, column);
         if (j >= 1) tally += COUNT_W'(lone_pixel(sweep));
      end
      frame_count = tally;
      restart_frame();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_cfg  = FRAME_WIDTH_RESET;
         height_cfg = FRAME_HEIGHT_RESET;
         restart_frame();
         counts_due.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               REG_FRAME_WIDTH:  width_cfg  = csr_pwdata[CFG_W-1:0];
               REG_FRAME_HEIGHT: height_cfg = csr_pwdata[CFG_W-1:0];
               default: ;
            endcase
            restart_frame();
         end
         if (rsp_valid && rsp_ready) begin
            if (counts_due.size() == 0) begin
               $display("%0t: count transfer with none due, expected nothing, actual %0d",
                        $time, rsp_isolated_count);
               fail_count++;
            end else begin
               due = counts_due.pop_front();
               if (rsp_isolated_count !== due) begin
                  $display("%0t: isolated_count mismatch, expected %0d, actual %0d",
                           $time, due, rsp_isolated_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (take_pixel(req_pixel, finished)) counts_due.push_back(finished);
         end
      end
      counts_pending <= counts_due.size();
   end

endmodule

FILE: dv/isolated_pixel_counter_tb.sv
// Testbench top for the isolated pixel counter: clock, reset, pixel and register stimulus,
// result back-pressure and the verdict. Depends on ipc_pkg, isolated_pixel_counter and
// isolated_count_checker, which does all prediction and comparison.
module isolated_pixel_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipc_pkg::*;

   // run length: roughly this many pixel transfers, the last stretch without idling
   localparam int unsigned TOTAL_ITEMS     = 1950;
   localparam int unsigned CALM_ITEMS      = 300;
   // phase that runs tiny frames against a long rsp hold-off
   localparam int unsigned PRESSURE_PHASE  = 1;
   localparam int unsigned HOLD_OFF_CYCLES = 600;
   // cycles allowed after the last count for any work on a part-frame to die out:
   // a last-row sweep is about a row long, plus the pipeline and queue
   localparam int unsigned DRAIN_CYCLES    = 2 * DEF_MAX_WIDTH + 64;
   // several times the slowest legal run (all gaps and stalls at their longest)
   localparam int unsigned TIMEOUT_NS      = 10_000_000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [COUNT_W-1:0]    rsp_isolated_count;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    counts_pending;

   // stimulus state; stall_pct, calm and hold_off_request are shared with the rsp process
   int unsigned           items_sent;
   int unsigned           gap_pct;
   int unsigned           stall_pct;
   bit                    calm;
   bit                    hold_off_request;
   // register values last written, to size the frames
   logic [CFG_W-1:0]      cur_w = FRAME_WIDTH_RESET;
   logic [CFG_W-1:0]      cur_h = FRAME_HEIGHT_RESET;

   isolated_pixel_counter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_isolated_count (rsp_isolated_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   isolated_count_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_isolated_count (rsp_isolated_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .fail_count         (fail_count),
      .counts_pending     (counts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a transfer never completes
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // size a register value takes effect as: zero acts as one, too large acts as the bound
   function automatic int unsigned effective(input logic [CFG_W-1:0] v,
                                             input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // One register write: setup cycle, then access cycle; the register takes the
   // value at the access edge (pready is tied high). Drop the select afterwards and
   // idle before returning so back-to-back writes never touch the same signal twice
   // in one time step. Upper data bits carry noise; only the low byte is the register.
   task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
      logic [31:0] noise;
      noise = $urandom();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {noise[CSR_DATA_W-CFG_W-1:0], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_FRAME_WIDTH) cur_w = value;
      else cur_h = value;
   endtask

   // Offer one pixel and hold it until the transfer. A sender gap, when drawn, first
   // drops valid; otherwise valid stays high across consecutive pixels. Idling stops
   // for good once the run nears its end.
   task automatic send_pixel(input logic px);
      calm = (items_sent + CALM_ITEMS >= TOTAL_ITEMS);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // random pixels, set with the given percentage
   task automatic send_pixels(input int unsigned n, input int unsigned density);
      repeat (n) send_pixel($urandom_range(0, 99) < density);
   endtask

   // fixed pattern, bit 0 first in raster order
   task automatic send_pattern(input logic [15:0] bits, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_pixel(bits[i]);
   endtask

   // Close a phase: drop valid, let the checker catch up with the last transfer, wait for
   // every due count, then give any part-frame time to drain before the next write.
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (counts_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // rsp side: mostly ready, random stall bursts, and one long hold-off on request so the
   // block's output register, queue and input all back up
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            for (int unsigned n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] w_set;
      logic [CFG_W-1:0] h_set;
      int unsigned      frame_len;
      int unsigned      frames;
      int unsigned      density;
      int unsigned      phase;
      req_valid   <= 1'b0;
      req_pixel   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      items_sent       = 0;
      gap_pct          = 20;
      stall_pct        = 20;
      calm             = 1'b0;
      hold_off_request = 1'b0;
      phase            = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on a 3x3 frame: a lone centre pixel (count one), a full frame
      // (count zero), then a part-frame cut short by a register write.
      write_reg(REG_FRAME_WIDTH, 8'd3);
      write_reg(REG_FRAME_HEIGHT, 8'd3);
      send_pattern(16'h0010, 9);
      send_pattern(16'h01FF, 9);
      send_pattern(16'h0005, 4);
      finish_phase();
      // zero sizes act as a 1x1 frame: a set pixel alone is isolated, a clear one is not
      write_reg(REG_FRAME_WIDTH, 8'd0);
      write_reg(REG_FRAME_HEIGHT, 8'd0);
      send_pattern(16'h0001, 2);
      finish_phase();

      // Random phases: new frame size, idling rates and pixel density each time; a few
      // whole frames, sometimes followed by a part-frame that the next write abandons.
      while (items_sent < TOTAL_ITEMS) begin
         phase++;
         calm      = (items_sent + CALM_ITEMS >= TOTAL_ITEMS);
         gap_pct   = 15 * $urandom_range(0, 2);
         stall_pct = 10 * $urandom_range(0, 3);
         density   = 50 >> $urandom_range(0, 4);
         if (phase == PRESSURE_PHASE) begin
            w_set   = 8'd4;
            h_set   = 8'd3;
            gap_pct = 0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  w_set = 8'($urandom_range(1, 12));
                  h_set = 8'($urandom_range(1, 12));
               end
               6: begin
                  // widest rows, including values above the bound
                  w_set = $urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(129, 255));
                  h_set = 8'($urandom_range(0, 2));
               end
               7: begin
                  // tallest frames on narrow rows
                  w_set = 8'($urandom_range(0, 2));
                  h_set = $urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(129, 255));
               end
               8: begin
                  w_set = 8'($urandom_range(0, 3));
                  h_set = 8'($urandom_range(0, 3));
               end
               default: begin
                  w_set = 8'($urandom_range(10, 24));
                  h_set = 8'($urandom_range(10, 16));
               end
            endcase
         end

         // every write restarts the frame; sometimes write just one register
         if (phase != PRESSURE_PHASE && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, w_set);
            else write_reg(REG_FRAME_HEIGHT, h_set);
         end else if ($urandom_range(0, 1)) begin
            write_reg(REG_FRAME_WIDTH, w_set);
            write_reg(REG_FRAME_HEIGHT, h_set);
         end else begin
            write_reg(REG_FRAME_HEIGHT, h_set);
            write_reg(REG_FRAME_WIDTH, w_set);
         end

         frame_len = effective(cur_w, DEF_MAX_WIDTH) * effective(cur_h, DEF_MAX_HEIGHT);
         if (phase == PRESSURE_PHASE) begin
            // many tiny frames while rsp is held off: counts pile up and input stalls
            frames = 8;
            hold_off_request = 1'b1;
         end else begin
            frames = (frame_len > 150) ? 1 : $urandom_range(1, 4);
            // keep the run close to its target length
            while (frames > 1 && items_sent + frames * frame_len > TOTAL_ITEMS) frames--;
         end
         send_pixels(frames * frame_len, density);
         if (phase != PRESSURE_PHASE && frame_len > 1 && items_sent < TOTAL_ITEMS
             && $urandom_range(0, 3) == 0)
            send_pixels($urandom_range(1, frame_len - 1), density);
         finish_phase();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
